/* sv/bws_pkg.sv */
// Shared types and constants of the backwash station sequencer.
package bws_pkg;

  localparam int MAX_STATIONS = 16;
  localparam int STATION_W    = 5;
  localparam int CYCLE_W      = 14;
  localparam int APB_AW       = 5;

  localparam logic [CYCLE_W-1:0]   CYCLE_WRAP  = CYCLE_W'(9999);
  localparam logic [STATION_W-1:0] STATION_MAX = STATION_W'(MAX_STATIONS);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_STOP  = 2'd1,
    OP_INIT  = 2'd2,
    OP_START = 2'd3
  } bws_op_t;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_STANDBY = 3'd1,
    MODE_FLUSH   = 3'd2,
    MODE_GAP     = 3'd3,
    MODE_STOP    = 3'd4
  } bws_mode_t;

  typedef enum logic [1:0] {
    PAGE_SETTINGS = 2'd0,
    PAGE_REALTIME = 2'd1,
    PAGE_FLUSH    = 2'd2,
    PAGE_GAP      = 2'd3
  } bws_page_t;

  typedef enum logic [2:0] {
    REG_STANDBY_PERIOD = 3'd0,
    REG_PRESSURE_LIMIT = 3'd1,
    REG_FLUSH_TIME     = 3'd2,
    REG_STATION_COUNT  = 3'd3,
    REG_GAP_TIME       = 3'd4
  } bws_reg_t;

  localparam logic VALVE_FORWARD = 1'b0;
  localparam logic VALVE_OPEN    = 1'b1;

  typedef struct packed {
    logic [23:0]          standby_period_s;
    logic [15:0]          pressure_limit;
    logic [15:0]          flush_time_s;
    logic [STATION_W-1:0] station_count;
    logic [7:0]           gap_time_s;
  } bws_cfg_t;

  typedef struct packed {
    bws_mode_t            mode;
    logic [STATION_W-1:0] station_now;
    logic                 valve_valid;
    logic [STATION_W-1:0] valve_station;
    logic                 valve_dir;
    logic                 page_valid;
    bws_page_t            page;
    logic [CYCLE_W-1:0]   cycles_done;
  } bws_res_t;

  function automatic logic [STATION_W-1:0] stations_eff(input logic [STATION_W-1:0] n);
    stations_eff = (n > STATION_MAX) ? STATION_MAX : n;
  endfunction

endpackage

/* sv/bws_if.sv */
// Request and result channel interfaces of the backwash station sequencer.
interface bws_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] pressure;

  modport source (output valid, op, pressure, input ready);
  modport sink   (input valid, op, pressure, output ready);
endinterface

interface bws_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [4:0] station_now;
  logic       valve_valid;
  logic [4:0] valve_station;
  logic       valve_dir;
  logic       page_valid;
  logic [1:0] page;
  logic [13:0] cycles_done;

  modport source (output valid, mode, station_now, valve_valid, valve_station, valve_dir,
                  page_valid, page, cycles_done, input ready);
  modport sink   (input valid, mode, station_now, valve_valid, valve_station, valve_dir,
                  page_valid, page, cycles_done, output ready);
endinterface

/* sv/backwash_station_sequencer_unit.sv */
// Backwash station sequencer top level.
// A request passes the input register, then its result the result register, once processed.
// One request per cycle unless a result is stalled; the state updates once per request.
// A pending result is held while the next request is taken into the input register.
// Reset (rst, synchronous): init mode, counters and station cleared, page settings,
// configuration registers return to their defaults.
module backwash_station_sequencer_unit import bws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bws_cmd_if.sink           cmd,
  bws_res_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  bws_cfg_t cfg;

  bws_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bws_core u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .res (res)
  );

endmodule

/* sv/bws_cfg.sv */
// APB configuration register file of the backwash station sequencer.
module bws_cfg import bws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output bws_cfg_t          cfg
);

  logic     wr;
  bws_reg_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = bws_reg_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.standby_period_s <= 24'd3600;
      cfg.pressure_limit   <= 16'hFFFF;
      cfg.flush_time_s     <= 16'd30;
      cfg.station_count    <= STATION_W'(4);
      cfg.gap_time_s       <= 8'd5;
    end else if (wr) begin
      case (idx)
        REG_STANDBY_PERIOD: cfg.standby_period_s <= pwdata[23:0];
        REG_PRESSURE_LIMIT: cfg.pressure_limit   <= pwdata[15:0];
        REG_FLUSH_TIME:     cfg.flush_time_s     <= pwdata[15:0];
        REG_STATION_COUNT:  cfg.station_count    <= pwdata[STATION_W-1:0];
        REG_GAP_TIME:       cfg.gap_time_s       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STANDBY_PERIOD: prdata = {8'd0, cfg.standby_period_s};
      REG_PRESSURE_LIMIT: prdata = {16'd0, cfg.pressure_limit};
      REG_FLUSH_TIME:     prdata = {16'd0, cfg.flush_time_s};
      REG_STATION_COUNT:  prdata = {{(32-STATION_W){1'b0}}, cfg.station_count};
      REG_GAP_TIME:       prdata = {24'd0, cfg.gap_time_s};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

/* sv/bws_core.sv */
// Sequencer state, request register and result register.
module bws_core import bws_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  bws_cfg_t cfg,
  bws_cmd_if.sink   cmd,
  bws_res_if.source res
);

  logic        in_vld;
  bws_op_t     op_q;
  logic [15:0] pres_q;
  logic        proc;

  bws_mode_t            mode, mode_next;
  logic [STATION_W-1:0] station, station_next;
  logic [23:0]          standby_count, standby_next;
  logic [15:0]          flush_left, flush_next;
  logic [7:0]           gap_left, gap_next;
  logic [CYCLE_W-1:0]   cycle_count, cycle_next;
  bws_page_t            page, page_next;

  logic                 valve_vld;
  logic                 valve_dir;
  logic [STATION_W-1:0] valve_station;
  logic                 page_vld;

  logic                 res_vld;
  bws_res_t             res_q;

  logic [23:0]          count_inc;
  logic                 sb_fire;
  logic                 fl_exp;
  logic                 gap_exp;
  logic [STATION_W:0]   st_inc;
  logic                 last_st;

  assign proc      = in_vld & (~res_vld | res.ready);
  assign cmd.ready = ~in_vld | proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (cmd.ready) begin
      in_vld <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid & cmd.ready) begin
      op_q   <= bws_op_t'(cmd.op);
      pres_q <= cmd.pressure;
    end
  end

  assign count_inc = (standby_count != '1) ? standby_count + 24'd1 : standby_count;
  assign sb_fire   = (count_inc >= cfg.standby_period_s) | (pres_q >= cfg.pressure_limit);
  assign fl_exp    = flush_left <= 16'd1;
  assign gap_exp   = gap_left <= 8'd1;
  assign st_inc    = {1'b0, station} + (STATION_W+1)'(1);
  assign last_st   = st_inc > {1'b0, stations_eff(cfg.station_count)};

  always_comb begin
    mode_next = mode;
    case (op_q)
      OP_TICK: begin
        case (mode)
          MODE_INIT:    mode_next = MODE_STANDBY;
          MODE_STANDBY: mode_next = sb_fire ? MODE_FLUSH : MODE_STANDBY;
          MODE_FLUSH:   mode_next = fl_exp ? (last_st ? MODE_STANDBY : MODE_GAP) : MODE_FLUSH;
          MODE_GAP:     mode_next = gap_exp ? MODE_FLUSH : MODE_GAP;
          default:      mode_next = mode;
        endcase
      end
      OP_STOP: mode_next = MODE_STOP;
      OP_INIT: mode_next = MODE_STANDBY;
      default: mode_next = MODE_FLUSH;
    endcase
  end

  always_comb begin
    station_next  = station;
    standby_next  = standby_count;
    flush_next    = flush_left;
    gap_next      = gap_left;
    cycle_next    = cycle_count;
    page_next     = page;
    valve_vld     = 1'b0;
    valve_dir     = VALVE_FORWARD;
    valve_station = '0;
    page_vld      = 1'b0;
    case (op_q)
      OP_TICK: begin
        case (mode)
          MODE_INIT: begin
            station_next = STATION_W'(1);
            flush_next   = cfg.flush_time_s;
            standby_next = '0;
            page_next    = PAGE_REALTIME;
            page_vld     = 1'b1;
          end
          MODE_STANDBY: begin
            standby_next = count_inc;
            if (sb_fire) begin
              standby_next  = '0;
              valve_vld     = 1'b1;
              valve_station = station;
              page_next     = PAGE_FLUSH;
              page_vld      = 1'b1;
            end
          end
          MODE_FLUSH: begin
            if (fl_exp) begin
              flush_next    = cfg.flush_time_s;
              valve_vld     = 1'b1;
              valve_dir     = VALVE_OPEN;
              valve_station = station;
              page_vld      = 1'b1;
              if (last_st) begin
                station_next = STATION_W'(1);
                standby_next = '0;
                page_next    = PAGE_REALTIME;
                cycle_next   = (cycle_count >= CYCLE_WRAP) ? '0 :
                               cycle_count + CYCLE_W'(1);
              end else begin
                station_next = st_inc[STATION_W-1:0];
                gap_next     = cfg.gap_time_s;
                page_next    = PAGE_GAP;
              end
            end else begin
              flush_next = flush_left - 16'd1;
            end
          end
          MODE_GAP: begin
            if (gap_exp) begin
              gap_next      = cfg.gap_time_s;
              valve_vld     = 1'b1;
              valve_station = station;
              page_next     = PAGE_FLUSH;
              page_vld      = 1'b1;
            end else begin
              gap_next = gap_left - 8'd1;
            end
          end
          default: begin
            station_next = STATION_W'(1);
            flush_next   = cfg.flush_time_s;
            gap_next     = cfg.gap_time_s;
            standby_next = '0;
          end
        endcase
      end
      OP_STOP: begin
        page_next = PAGE_SETTINGS;
        page_vld  = 1'b1;
      end
      OP_INIT: begin
        station_next = STATION_W'(1);
        flush_next   = cfg.flush_time_s;
        standby_next = '0;
        page_next    = PAGE_REALTIME;
        page_vld     = 1'b1;
      end
      default: begin
        if (mode == MODE_INIT) begin
          station_next = STATION_W'(1);
          flush_next   = cfg.flush_time_s;
          standby_next = '0;
        end
        valve_vld     = 1'b1;
        valve_station = station_next;
        page_next     = PAGE_FLUSH;
        page_vld      = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_INIT;
      station       <= '0;
      standby_count <= '0;
      flush_left    <= '0;
      gap_left      <= '0;
      cycle_count   <= '0;
      page          <= PAGE_SETTINGS;
    end else if (proc) begin
      mode          <= mode_next;
      station       <= station_next;
      standby_count <= standby_next;
      flush_left    <= flush_next;
      gap_left      <= gap_next;
      cycle_count   <= cycle_next;
      page          <= page_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (proc) begin
      res_vld <= 1'b1;
    end else if (res.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_q.mode          <= mode_next;
      res_q.station_now   <= station_next;
      res_q.valve_valid   <= valve_vld;
      res_q.valve_station <= valve_station;
      res_q.valve_dir     <= valve_dir;
      res_q.page_valid    <= page_vld;
      res_q.page          <= page_next;
      res_q.cycles_done   <= cycle_next;
    end
  end

  assign res.valid         = res_vld;
  assign res.mode          = res_q.mode;
  assign res.station_now   = res_q.station_now;
  assign res.valve_valid   = res_q.valve_valid;
  assign res.valve_station = res_q.valve_station;
  assign res.valve_dir     = res_q.valve_dir;
  assign res.page_valid    = res_q.page_valid;
  assign res.page          = res_q.page;
  assign res.cycles_done   = res_q.cycles_done;

`ifndef SYNTHESIS
  a_cycle_range: assert property (@(posedge clk) disable iff (rst)
    cycle_count <= CYCLE_WRAP)
    else $error("cycle count past wrap value");

  a_proc_result: assert property (@(posedge clk) disable iff (rst)
    proc |=> res_vld)
    else $error("processed request left no result");

  a_valve_page: assert property (@(posedge clk) disable iff (rst)
    res_vld & res_q.valve_valid |-> res_q.page_valid)
    else $error("valve command without page change");

  a_open_mode: assert property (@(posedge clk) disable iff (rst)
    proc & valve_vld & (valve_dir == VALVE_OPEN) |=>
      (mode == MODE_GAP) || (mode == MODE_STANDBY))
    else $error("valve opened outside end of flush");

  a_held_request: assert property (@(posedge clk) disable iff (rst)
    in_vld & ~proc |=> in_vld & $stable(op_q) & $stable(pres_q))
    else $error("pending request lost");
`endif

endmodule
